### src/crcfr_pkg.sv
// ============================================================================
// crcfr_pkg
// Types, codes and the per-byte CRC function of the framed response receiver.
// ============================================================================
package crcfr_pkg;

	localparam logic [15:0] CRC_START    = 16'hFFFF;
	localparam logic [9:0]  HEADER_BYTES = 10'd4;

	// Register indexes of the configuration port
	localparam logic [1:0] REG_MAX_LEN  = 2'd0;
	localparam logic [1:0] REG_ACK      = 2'd1;
	localparam logic [1:0] REG_NACK     = 2'd2;
	localparam logic [1:0] REG_CRC_POLY = 2'd3;

	// Reset values of the registers
	localparam logic [7:0]  RST_MAX_LEN  = 8'd64;
	localparam logic [7:0]  RST_ACK      = 8'd6;
	localparam logic [7:0]  RST_NACK     = 8'd21;
	localparam logic [15:0] RST_CRC_POLY = 16'hA001;

	// Request action codes
	localparam logic [1:0] ACT_BYTE        = 2'd0;
	localparam logic [1:0] ACT_ARM_FRAME   = 2'd1;
	localparam logic [1:0] ACT_ARM_CONFIRM = 2'd2;

	typedef enum logic [3:0] {
		PH_ADDR    = 4'd0,
		PH_SEQ     = 4'd1,
		PH_CMD     = 4'd2,
		PH_LEN     = 4'd3,
		PH_PAYLOAD = 4'd4,
		PH_CRC_HI  = 4'd5,
		PH_CRC_LO  = 4'd6,
		PH_CONFIRM = 4'd7,
		PH_FAULT   = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_STORED  = 3'd1,
		EV_CRCBYTE = 3'd2,
		EV_FAULT   = 3'd3,
		EV_VALID   = 3'd4,
		EV_CRCERR  = 3'd5,
		EV_ACK     = 3'd6,
		EV_NACK    = 3'd7
	} event_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] rx_byte;
		logic [7:0] expected_address;
		logic [7:0] expected_command;
	} req_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [8:0] byte_index;
		logic [7:0] byte_value;
		logic [7:0] payload_length;
	} res_t;

	typedef struct packed {
		logic [1:0]  reg_index;
		logic [15:0] wdata;
	} cfg_t;

	// Reflected CRC-16 update with one byte, low bit first
	function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
		input logic [7:0] data, input logic [15:0] poly);
		logic [15:0] crc;
		crc = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ poly;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

endpackage

### src/crcfr_stream_if.sv
// ============================================================================
// crcfr_stream_if
// Valid/ready channel carrying one payload struct per transfer.
// ============================================================================
interface crcfr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### src/crc_checked_frame_receiver_core.sv
// ============================================================================
// crc_checked_frame_receiver_core
// Framed response receiver: header match, length limit, CRC-16 check.
// ============================================================================
// Every request on rx_in yields exactly one result on res_out. A request is
// taken in the cycle it is offered whenever the result register is empty or
// being drained, so the block sustains one request per clock; the result of a
// request appears in the following cycle. The whole frame step, including the
// eight-bit reflected CRC fold, is a single combinational pass from the frame
// state registers into the result register and back into the state. Arm
// requests latch the expected address and command; received bytes walk the
// frame phases (address, sequence, command, length, payload, CRC high, CRC
// low). A mismatch or an over-long length parks the block in a sticky fault
// phase left only by a new arm. Configuration writes are always taken
// (cfg.ready is tied high) and should only be issued while the block is idle.
// ============================================================================
module crc_checked_frame_receiver_core (
	input logic              clk,
	input logic              arst_n,
	crcfr_stream_if.sink     rx_in,
	crcfr_stream_if.source   res_out,
	crcfr_stream_if.sink     cfg
);

	// Configuration registers
	logic [7:0]  max_len_q;
	logic [7:0]  ack_code_q;
	logic [7:0]  nack_code_q;
	logic [15:0] crc_poly_q;

	// Frame state
	crcfr_pkg::phase_t phase_q, phase_nxt;
	logic [8:0]  byte_count_q, byte_count_nxt;
	logic [7:0]  frame_len_q, frame_len_nxt;
	logic [15:0] crc_q, crc_nxt;
	logic [7:0]  crc_hi_q;
	logic [7:0]  lat_addr_q, lat_cmd_q;

	// Result register
	crcfr_pkg::res_t res_q, res_nxt;
	logic            res_valid_q;

	logic            in_acc, cfg_acc, is_arm;
	crcfr_pkg::req_t req;
	logic [7:0]      rx_b;
	logic [15:0]     crc_base, crc_folded;
	logic [8:0]      cnt_base;
	logic            addr_ok, cmd_ok, len_ok, payload_last, crc_ok;
	logic            store;
	crcfr_pkg::event_t ev;

	// Take a new request whenever the result slot is free or draining
	assign rx_in.ready = !res_valid_q || res_out.ready;
	assign in_acc      = rx_in.valid && rx_in.ready;
	assign cfg.ready   = 1'b1;
	assign cfg_acc     = cfg.valid;

	assign req     = rx_in.data;
	assign rx_b    = req.rx_byte;
	assign is_arm  = (req.action == crcfr_pkg::ACT_ARM_FRAME) ||
		(req.action == crcfr_pkg::ACT_ARM_CONFIRM);

	// A matching address restarts the frame: count and CRC start fresh
	assign crc_base   = (phase_q == crcfr_pkg::PH_ADDR) ? crcfr_pkg::CRC_START : crc_q;
	assign cnt_base   = (phase_q == crcfr_pkg::PH_ADDR) ? 9'd0 : byte_count_q;
	assign crc_folded = crcfr_pkg::crc_fold(crc_base, rx_b, crc_poly_q);

	assign addr_ok      = (rx_b == lat_addr_q);
	assign cmd_ok       = (rx_b == lat_cmd_q);
	assign len_ok       = (rx_b <= max_len_q);
	assign payload_last = ({1'b0, byte_count_q} + 10'd1) >=
		(crcfr_pkg::HEADER_BYTES + {2'b00, frame_len_q});
	assign crc_ok       = ({crc_hi_q, rx_b} == crc_q);

	// ---------------- next phase ----------------
	always_comb begin
		phase_nxt = phase_q;
		case (req.action)
			crcfr_pkg::ACT_ARM_FRAME: begin
				phase_nxt = crcfr_pkg::PH_ADDR;
			end
			crcfr_pkg::ACT_ARM_CONFIRM: begin
				phase_nxt = crcfr_pkg::PH_CONFIRM;
			end
			crcfr_pkg::ACT_BYTE: begin
				case (phase_q)
					crcfr_pkg::PH_ADDR: begin
						phase_nxt = addr_ok ? crcfr_pkg::PH_SEQ : crcfr_pkg::PH_FAULT;
					end
					crcfr_pkg::PH_SEQ: begin
						phase_nxt = crcfr_pkg::PH_CMD;
					end
					crcfr_pkg::PH_CMD: begin
						phase_nxt = cmd_ok ? crcfr_pkg::PH_LEN : crcfr_pkg::PH_FAULT;
					end
					crcfr_pkg::PH_LEN: begin
						if (!len_ok) begin
							phase_nxt = crcfr_pkg::PH_FAULT;
						end else if (rx_b == 8'd0) begin
							phase_nxt = crcfr_pkg::PH_CRC_HI;
						end else begin
							phase_nxt = crcfr_pkg::PH_PAYLOAD;
						end
					end
					crcfr_pkg::PH_PAYLOAD: begin
						if (payload_last) begin
							phase_nxt = crcfr_pkg::PH_CRC_HI;
						end
					end
					crcfr_pkg::PH_CRC_HI: begin
						phase_nxt = crcfr_pkg::PH_CRC_LO;
					end
					crcfr_pkg::PH_CRC_LO: begin
						phase_nxt = crcfr_pkg::PH_ADDR;
					end
					crcfr_pkg::PH_CONFIRM: begin
						phase_nxt = crcfr_pkg::PH_CONFIRM;
					end
					default: begin
						phase_nxt = crcfr_pkg::PH_FAULT;
					end
				endcase
			end
			default: begin
				phase_nxt = phase_q;
			end
		endcase
	end

	// ---------------- event, datapath and result ----------------
	always_comb begin
		ev             = crcfr_pkg::EV_NONE;
		store          = 1'b0;
		byte_count_nxt = byte_count_q;
		frame_len_nxt  = frame_len_q;
		crc_nxt        = crc_q;
		res_nxt        = '0;
		case (req.action)
			crcfr_pkg::ACT_ARM_FRAME, crcfr_pkg::ACT_ARM_CONFIRM: begin
				byte_count_nxt = 9'd0;
				frame_len_nxt  = 8'd0;
				crc_nxt        = crcfr_pkg::CRC_START;
			end
			crcfr_pkg::ACT_BYTE: begin
				res_nxt.byte_value = rx_b;
				case (phase_q)
					crcfr_pkg::PH_ADDR: begin
						if (addr_ok) begin
							store         = 1'b1;
							frame_len_nxt = 8'd0;
						end else begin
							ev = crcfr_pkg::EV_FAULT;
						end
					end
					crcfr_pkg::PH_SEQ, crcfr_pkg::PH_PAYLOAD: begin
						store = 1'b1;
					end
					crcfr_pkg::PH_CMD: begin
						if (cmd_ok) begin
							store = 1'b1;
						end else begin
							ev = crcfr_pkg::EV_FAULT;
						end
					end
					crcfr_pkg::PH_LEN: begin
						if (len_ok) begin
							store         = 1'b1;
							frame_len_nxt = rx_b;
						end else begin
							ev = crcfr_pkg::EV_FAULT;
						end
					end
					crcfr_pkg::PH_CRC_HI: begin
						ev = crcfr_pkg::EV_CRCBYTE;
					end
					crcfr_pkg::PH_CRC_LO: begin
						ev             = crc_ok ? crcfr_pkg::EV_VALID : crcfr_pkg::EV_CRCERR;
						byte_count_nxt = 9'd0;
					end
					crcfr_pkg::PH_CONFIRM: begin
						if (rx_b == ack_code_q) begin
							ev = crcfr_pkg::EV_ACK;
						end else if (rx_b == nack_code_q) begin
							ev = crcfr_pkg::EV_NACK;
						end else begin
							res_nxt.byte_value = 8'd0;
						end
					end
					default: begin
						ev = crcfr_pkg::EV_FAULT;
					end
				endcase
				if (store) begin
					ev                 = crcfr_pkg::EV_STORED;
					res_nxt.byte_index = cnt_base;
					crc_nxt            = crc_folded;
					byte_count_nxt     = cnt_base + 9'd1;
				end
			end
			default: begin
				ev = crcfr_pkg::EV_NONE;
			end
		endcase
		res_nxt.event_res      = ev;
		res_nxt.payload_length = frame_len_nxt;
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q   <= crcfr_pkg::RST_MAX_LEN;
			ack_code_q  <= crcfr_pkg::RST_ACK;
			nack_code_q <= crcfr_pkg::RST_NACK;
			crc_poly_q  <= crcfr_pkg::RST_CRC_POLY;
		end else if (cfg_acc) begin
			case (cfg.data.reg_index)
				crcfr_pkg::REG_MAX_LEN:  max_len_q   <= cfg.data.wdata[7:0];
				crcfr_pkg::REG_ACK:      ack_code_q  <= cfg.data.wdata[7:0];
				crcfr_pkg::REG_NACK:     nack_code_q <= cfg.data.wdata[7:0];
				crcfr_pkg::REG_CRC_POLY: crc_poly_q  <= cfg.data.wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= crcfr_pkg::PH_ADDR;
			byte_count_q <= 9'd0;
			frame_len_q  <= 8'd0;
			crc_q        <= crcfr_pkg::CRC_START;
			lat_addr_q   <= 8'd0;
			lat_cmd_q    <= 8'd0;
		end else if (in_acc) begin
			phase_q      <= phase_nxt;
			byte_count_q <= byte_count_nxt;
			frame_len_q  <= frame_len_nxt;
			crc_q        <= crc_nxt;
			if (is_arm) begin
				lat_addr_q <= req.expected_address;
				lat_cmd_q  <= req.expected_command;
			end
		end
	end

	// Hold the first CRC byte until the second arrives
	always_ff @(posedge clk) begin
		if (in_acc && (req.action == crcfr_pkg::ACT_BYTE) &&
			(phase_q == crcfr_pkg::PH_CRC_HI)) begin
			crc_hi_q <= rx_b;
		end
	end

	// Result slot: load on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_acc) begin
			res_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q <= res_nxt;
		end
	end

	assign res_out.valid = res_valid_q;
	assign res_out.data  = res_q;

	// ---------------- assertions ----------------
	a_result_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> res_valid_q)
		else $error("accepted request left no result");

	a_arm_frame_phase: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (req.action == crcfr_pkg::ACT_ARM_FRAME) |=>
			(phase_q == crcfr_pkg::PH_ADDR) && (byte_count_q == 9'd0))
		else $error("arm did not restart the frame");

	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == crcfr_pkg::PH_FAULT) && !(in_acc && is_arm) |=>
			(phase_q == crcfr_pkg::PH_FAULT))
		else $error("fault phase left without an arm");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= 9'd259)
		else $error("byte count beyond the longest frame");

endmodule

### sim/crcfr_checker.sv
// ============================================================================
// crcfr_checker
// Tracks the receiver's frame state, predicts each result and compares it.
// ============================================================================
module crcfr_checker
	import crcfr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic rx_valid,
	input  logic rx_ready,
	input  req_t rx_data,
	input  logic res_valid,
	input  logic res_ready,
	input  res_t res_data,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  cfg_t cfg_data,
	output int   fail_count,
	output int   waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 40;

	// Register copies
	logic [7:0]  lim_len;
	logic [7:0]  ack_q;
	logic [7:0]  nack_q;
	logic [15:0] poly_q;

	// Frame state
	phase_t      rx_state;
	logic [8:0]  pos;
	logic [7:0]  len_q;
	logic [15:0] crc_q;
	logic [7:0]  crc_hi_q;
	logic [7:0]  want_addr;
	logic [7:0]  want_cmd;

	res_t        pending_res[$];
	int          mismatches = 0;

	function automatic logic [15:0] crc16_byte(input logic [15:0] acc,
		input logic [7:0] b, input logic [15:0] poly);
		logic [15:0] r;
		logic        lsb;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			lsb = r[0] ^ b[i];
			r = {1'b0, r[15:1]} ^ (lsb ? poly : 16'h0000);
		end
		return r;
	endfunction

	task automatic note_mismatch(input string field, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, field, exp_v, act_v);
		end
	endtask

	// Advance the frame state by one request and form its result.
	task automatic predict_step(input req_t r, output res_t o);
		event_t     ev;
		logic [8:0] idx;
		logic [7:0] val;
		logic       keep;
		ev = EV_NONE;
		idx = '0;
		val = '0;
		keep = 1'b0;
		case (r.action)
			ACT_ARM_FRAME, ACT_ARM_CONFIRM: begin
				want_addr = r.expected_address;
				want_cmd = r.expected_command;
				pos = '0;
				len_q = '0;
				crc_q = CRC_START;
				crc_hi_q = '0;
				rx_state = (r.action == ACT_ARM_FRAME) ? PH_ADDR : PH_CONFIRM;
			end
			ACT_BYTE: begin
				val = r.rx_byte;
				case (rx_state)
					PH_ADDR: begin
						if (r.rx_byte != want_addr) begin
							rx_state = PH_FAULT;
							ev = EV_FAULT;
						end else begin
							pos = '0;
							len_q = '0;
							crc_q = CRC_START;
							keep = 1'b1;
							rx_state = PH_SEQ;
						end
					end
					PH_SEQ: begin
						keep = 1'b1;
						rx_state = PH_CMD;
					end
					PH_CMD: begin
						if (r.rx_byte != want_cmd) begin
							rx_state = PH_FAULT;
							ev = EV_FAULT;
						end else begin
							keep = 1'b1;
							rx_state = PH_LEN;
						end
					end
					PH_LEN: begin
						if (r.rx_byte > lim_len) begin
							rx_state = PH_FAULT;
							ev = EV_FAULT;
						end else begin
							keep = 1'b1;
							len_q = r.rx_byte;
							rx_state = (r.rx_byte == 8'd0) ? PH_CRC_HI : PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						keep = 1'b1;
						if ({1'b0, pos} + 10'd1 >= HEADER_BYTES + {2'b00, len_q}) begin
							rx_state = PH_CRC_HI;
						end
					end
					PH_CRC_HI: begin
						crc_hi_q = r.rx_byte;
						ev = EV_CRCBYTE;
						rx_state = PH_CRC_LO;
					end
					PH_CRC_LO: begin
						ev = ({crc_hi_q, r.rx_byte} == crc_q) ? EV_VALID : EV_CRCERR;
						rx_state = PH_ADDR;
						pos = '0;
					end
					PH_CONFIRM: begin
						if (r.rx_byte == ack_q) begin
							ev = EV_ACK;
						end else if (r.rx_byte == nack_q) begin
							ev = EV_NACK;
						end else begin
							val = '0;
						end
					end
					default: begin
						rx_state = PH_FAULT;
						ev = EV_FAULT;
					end
				endcase
				if (keep) begin
					ev = EV_STORED;
					idx = pos;
					crc_q = crc16_byte(crc_q, r.rx_byte, poly_q);
					pos = pos + 9'd1;
				end
			end
			default: ;
		endcase
		o.event_res = ev;
		o.byte_index = idx;
		o.byte_value = val;
		o.payload_length = len_q;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		res_t want;
		if (!arst_n) begin
			lim_len = RST_MAX_LEN;
			ack_q = RST_ACK;
			nack_q = RST_NACK;
			poly_q = RST_CRC_POLY;
			rx_state = PH_ADDR;
			pos = '0;
			len_q = '0;
			crc_q = CRC_START;
			crc_hi_q = '0;
			want_addr = '0;
			want_cmd = '0;
			pending_res.delete();
			waiting <= 0;
			fail_count <= mismatches;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.reg_index)
					REG_MAX_LEN:  lim_len = cfg_data.wdata[7:0];
					REG_ACK:      ack_q = cfg_data.wdata[7:0];
					REG_NACK:     nack_q = cfg_data.wdata[7:0];
					REG_CRC_POLY: poly_q = cfg_data.wdata;
					default: ;
				endcase
			end
			// A result is registered, so it always trails its request; check
			// before queueing this edge's request.
			if (res_valid && res_ready) begin
				if (pending_res.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("%0t ns: result expected none, got event %0d index %0d",
							$time, res_data.event_res, res_data.byte_index);
					end
				end else begin
					want = pending_res.pop_front();
					if (res_data.event_res !== want.event_res) begin
						note_mismatch("event_res", want.event_res, res_data.event_res);
					end
					if (res_data.byte_index !== want.byte_index) begin
						note_mismatch("byte_index", want.byte_index, res_data.byte_index);
					end
					if (res_data.byte_value !== want.byte_value) begin
						note_mismatch("byte_value", want.byte_value, res_data.byte_value);
					end
					if (res_data.payload_length !== want.payload_length) begin
						note_mismatch("payload_length", want.payload_length,
							res_data.payload_length);
					end
				end
			end
			if (rx_valid && rx_ready) begin
				predict_step(rx_data, want);
				pending_res.push_back(want);
			end
			waiting <= pending_res.size();
			fail_count <= mismatches;
		end
	end

endmodule

### sim/crc_checked_frame_receiver_core_tb.sv
// ============================================================================
// crc_checked_frame_receiver_core_tb
// Drives framed responses, confirmations and noise into the receiver while
// a checker beside it predicts every result; back-pressure and sender gaps
// are random, and the registers are swept through several settings.
// ============================================================================
module crc_checked_frame_receiver_core_tb
	import crcfr_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	// Action code the block must ignore
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	// Cycles without any transfer before the run is declared hung
	localparam int WATCHDOG_LIMIT = 2000;
	// Random requests per register setting
	localparam int PHASE_REQS = 100;

	logic clk = 1'b0;
	logic arst_n;

	crcfr_stream_if #(.payload_t(req_t)) rx_if ();
	crcfr_stream_if #(.payload_t(res_t)) res_if ();
	crcfr_stream_if #(.payload_t(cfg_t)) cfg_if ();

	int fail_count;
	int waiting;

	// Generator's view of the block: register values and whether the block
	// sits at the address phase with cur_addr/cur_cmd latched.
	logic [7:0]  cur_max  = RST_MAX_LEN;
	logic [7:0]  cur_ack  = RST_ACK;
	logic [7:0]  cur_nack = RST_NACK;
	logic [15:0] cur_poly = RST_CRC_POLY;
	logic [7:0]  cur_addr = 8'h00;
	logic [7:0]  cur_cmd  = 8'h00;
	bit          armed    = 1'b0;

	bit idle_on  = 1'b1;   // random gaps and stalls enabled
	bit offer_up = 1'b0;   // rx valid is currently held high
	int quiet    = 0;

	// Coverage tallies for the closing summary
	int n_req     = 0;
	int n_writes  = 0;
	int n_frames  = 0;
	int n_bad_crc = 0;
	int n_broken  = 0;
	int n_confirm = 0;

	crc_checked_frame_receiver_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_in   (rx_if),
		.res_out (res_if),
		.cfg     (cfg_if)
	);

	crcfr_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_if.valid),
		.rx_ready   (rx_if.ready),
		.rx_data    (rx_if.data),
		.res_valid  (res_if.valid),
		.res_ready  (res_if.ready),
		.res_data   (res_if.data),
		.cfg_valid  (cfg_if.valid),
		.cfg_ready  (cfg_if.ready),
		.cfg_data   (cfg_if.data),
		.fail_count (fail_count),
		.waiting    (waiting)
	);

	always #1 clk = ~clk;

	// Result-side back-pressure: mostly short stalls, now and then a long one.
	initial begin : result_stall
		int hold;
		hold = 0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				res_if.ready <= 1'b0;
			end else if (hold > 0) begin
				res_if.ready <= 1'b0;
				hold--;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				res_if.ready <= 1'b0;
				hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// Abort when no channel has moved anything for too long.
	always @(posedge clk) begin
		if (!arst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
			(cfg_if.valid && cfg_if.ready)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
				quiet, waiting);
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Offer one request, with an optional random gap first, and hold it until
	// the block takes it. Valid stays high on return so that a following
	// request goes out back to back.
	task automatic send_req(input logic [1:0] act, input logic [7:0] b,
		input logic [7:0] addr, input logic [7:0] cmd);
		req_t r;
		int   gap;
		r.action = act;
		r.rx_byte = b;
		r.expected_address = addr;
		r.expected_command = cmd;
		gap = 0;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
		end
		if (gap != 0) begin
			if (offer_up) begin
				rx_if.valid <= 1'b0;
				offer_up = 1'b0;
			end
			repeat (gap) @(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.data <= r;
		offer_up = 1'b1;
		do @(posedge clk); while (!rx_if.ready);
		n_req++;
	endtask

	// Received byte; the arm fields carry noise the block must ignore.
	task automatic send_byte(input logic [7:0] b);
		send_req(ACT_BYTE, b, $urandom, $urandom);
	endtask

	// Arm request; the byte field carries noise.
	task automatic arm_req(input logic [1:0] act, input logic [7:0] addr,
		input logic [7:0] cmd);
		send_req(act, $urandom, addr, cmd);
	endtask

	// Drop valid and hold off until every outstanding result has come back.
	task automatic drain();
		if (offer_up) begin
			rx_if.valid <= 1'b0;
			offer_up = 1'b0;
		end
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
	endtask

	// Write all four registers back to back; call only with the block idle.
	task automatic program_regs(input logic [7:0] max_len, input logic [7:0] ack,
		input logic [7:0] nack, input logic [15:0] poly);
		cfg_t w;
		for (int k = 0; k < 4; k++) begin
			case (k)
				0: begin
					w.reg_index = REG_MAX_LEN;
					w.wdata = {8'h00, max_len};
				end
				1: begin
					w.reg_index = REG_ACK;
					w.wdata = {8'h00, ack};
				end
				2: begin
					w.reg_index = REG_NACK;
					w.wdata = {8'h00, nack};
				end
				default: begin
					w.reg_index = REG_CRC_POLY;
					w.wdata = poly;
				end
			endcase
			cfg_if.valid <= 1'b1;
			cfg_if.data <= w;
			do @(posedge clk); while (!cfg_if.ready);
			n_writes++;
		end
		cfg_if.valid <= 1'b0;
		cur_max = max_len;
		cur_ack = ack;
		cur_nack = nack;
		cur_poly = poly;
	endtask

	// Running CRC used to build frames, with the polynomial now programmed.
	function automatic logic [15:0] frame_crc(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		c = acc ^ {8'h00, b};
		repeat (8) c = c[0] ? ((c >> 1) ^ cur_poly) : (c >> 1);
		return c;
	endfunction

	// Full frame: header, payload, then the CRC high byte first; optionally
	// flip one CRC bit so the frame ends in a CRC error.
	task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd,
		input logic [7:0] len, input bit bad);
		logic [15:0] c;
		logic [7:0]  b;
		c = CRC_START;
		for (int i = 0; i < 4 + len; i++) begin
			case (i)
				0:       b = addr;
				2:       b = cmd;
				3:       b = len;
				default: b = $urandom;
			endcase
			c = frame_crc(c, b);
			send_byte(b);
		end
		if (bad) begin
			c = c ^ (16'h0001 << $urandom_range(0, 15));
		end
		send_byte(c[15:8]);
		send_byte(c[7:0]);
		n_frames++;
		if (bad) begin
			n_bad_crc++;
		end
	endtask

	// Payload length within the current limit, mostly short.
	function automatic logic [7:0] pick_len();
		if (cur_max == 8'd0) begin
			return 8'd0;
		end
		if ($urandom_range(0, 39) == 0) begin
			return cur_max;
		end
		if ($urandom_range(0, 19) == 0) begin
			return $urandom_range(0, cur_max);
		end
		return $urandom_range(0, (cur_max < 8'd8) ? cur_max : 8'd8);
	endfunction

	// One random episode: mostly well-formed frames, the rest broken frames,
	// confirmation exchanges, raw noise, or a full pause.
	task automatic random_episode();
		int         sel;
		logic [7:0] b;
		sel = $urandom_range(0, 19);
		if (sel < 11) begin
			// Re-arm now and then; otherwise chain onto the last frame.
			if (!armed || $urandom_range(0, 2) == 0) begin
				cur_addr = $urandom;
				cur_cmd = $urandom;
				arm_req(ACT_ARM_FRAME, cur_addr, cur_cmd);
				armed = 1'b1;
			end
			send_frame(cur_addr, cur_cmd, pick_len(), $urandom_range(0, 4) == 0);
		end else if (sel < 13) begin
			cur_addr = $urandom;
			cur_cmd = $urandom;
			arm_req(ACT_ARM_FRAME, cur_addr, cur_cmd);
			case ($urandom_range(0, 3))
				0: begin
					// wrong address
					b = $urandom_range(1, 255);
					send_byte(cur_addr ^ b);
				end
				1: begin
					// wrong command
					send_byte(cur_addr);
					send_byte($urandom);
					b = $urandom_range(1, 255);
					send_byte(cur_cmd ^ b);
				end
				2: begin
					// length over the limit, or truncated when no length can be
					send_byte(cur_addr);
					send_byte($urandom);
					send_byte(cur_cmd);
					if (cur_max != 8'hFF) begin
						send_byte($urandom_range(cur_max + 1, 255));
					end
				end
				default: begin
					// truncated frame with random bytes after the address
					send_byte(cur_addr);
					repeat ($urandom_range(0, 3)) send_byte($urandom);
				end
			endcase
			// trailing bytes land in the sticky fault, or wherever the frame stopped
			repeat ($urandom_range(0, 2)) send_byte($urandom);
			armed = 1'b0;
			n_broken++;
		end else if (sel < 16) begin
			arm_req(ACT_ARM_CONFIRM, $urandom, $urandom);
			repeat ($urandom_range(1, 6)) begin
				case ($urandom_range(0, 2))
					0:       b = cur_ack;
					1:       b = cur_nack;
					default: b = $urandom;
				endcase
				send_byte(b);
				n_confirm++;
			end
			armed = 1'b0;
		end else if (sel < 19) begin
			repeat ($urandom_range(1, 5)) send_req($urandom_range(0, 3), $urandom, $urandom,
				$urandom);
			armed = 1'b0;
		end else begin
			drain();
		end
	endtask

	initial begin : stimulus
		int goal;
		arst_n <= 1'b0;
		rx_if.valid <= 1'b0;
		rx_if.data <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset register values.
		// Empty frame with a good CRC, arm fields at the extremes.
		arm_req(ACT_ARM_FRAME, 8'hFF, 8'h00);
		send_frame(8'hFF, 8'h00, 8'd0, 1'b0);
		// Second frame without re-arming, one payload byte, corrupted CRC.
		send_frame(8'hFF, 8'h00, 8'd1, 1'b1);
		// Address mismatch enters the fault; a matching byte stays faulted.
		// Both still report the last frame's length.
		send_byte(8'h00);
		send_byte(8'hFF);
		// Unused action: no state change.
		send_req(ACT_UNUSED, 8'hFF, 8'hFF, 8'hFF);
		// Confirmation mode: acknowledge, negative acknowledge, other byte.
		arm_req(ACT_ARM_CONFIRM, 8'h00, 8'hFF);
		send_byte(RST_ACK);
		send_byte(RST_NACK);
		send_byte(8'hFF);
		// Command mismatch after a good address.
		arm_req(ACT_ARM_FRAME, 8'h00, 8'hFF);
		send_byte(8'h00);
		send_byte(8'h5A);
		send_byte(8'h00);
		armed = 1'b0;

		// Random part, one register setting per phase. Phase 0 keeps the
		// reset values, phase 1 runs with no idling at all, phase 2 sets the
		// lower extremes with equal ack and nack codes (ack must win).
		for (int p = 0; p < 6; p++) begin
			drain();
			case (p)
				1: program_regs(8'hFF, 8'h00, 8'hFF, 16'hFFFF);
				2: program_regs(8'h00, 8'h80, 8'h80, 16'h0000);
				3: program_regs(RST_MAX_LEN, RST_ACK, RST_NACK, RST_CRC_POLY);
				4: program_regs($urandom_range(0, 40), $urandom, $urandom, $urandom);
				5: program_regs($urandom_range(0, 255), $urandom, $urandom, $urandom);
				default: ;
			endcase
			idle_on = (p != 1);
			if (p == 1) begin
				// longest frame: byte index runs up to 258, its largest value
				cur_addr = $urandom;
				cur_cmd = $urandom;
				arm_req(ACT_ARM_FRAME, cur_addr, cur_cmd);
				send_frame(cur_addr, cur_cmd, 8'hFF, 1'b0);
				armed = 1'b1;
			end
			goal = n_req + PHASE_REQS;
			while (n_req < goal) random_episode();
		end

		// Let every result drain, then keep watching for stray results.
		drain();
		repeat (4) @(posedge clk);

		$display("Covered %0d requests and %0d register writes over 6 register settings",
			n_req, n_writes);
		$display("%0d full frames (%0d with a bad CRC), %0d broken frames, %0d confirm bytes",
			n_frames, n_bad_crc, n_broken, n_confirm);
		if (fail_count == 0 && waiting == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### filelist.f
src/crcfr_pkg.sv
src/crcfr_stream_if.sv
src/crc_checked_frame_receiver_core.sv
sim/crcfr_checker.sv
sim/crc_checked_frame_receiver_core_tb.sv
